// ----- src/pmc_pkg.sv -----
// Shared types and constants of the PID move controller.
package pmc_pkg;

	localparam int REG_COUNT = 8;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam int GAIN_W = 16;
	localparam int SUM_W = 32;

	localparam logic MODE_START = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;

	localparam logic [SUM_W-1:0] SUM_MAX = 32'h7FFF_FFFF;
	localparam logic [SUM_W-1:0] SUM_MIN = 32'h8000_0000;

	typedef enum logic [2:0] {
		REG_TARGET = 3'd0,
		REG_TURN = 3'd1,
		REG_DRV_P = 3'd2,
		REG_DRV_I = 3'd3,
		REG_DRV_D = 3'd4,
		REG_TRN_P = 3'd5,
		REG_TRN_I = 3'd6,
		REG_TRN_D = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_START = 2'd0,
		KIND_IDLE = 2'd1,
		KIND_RUN = 2'd2
	} kind_t;

	typedef struct packed {
		logic [GAIN_W-1:0] kp;
		logic [GAIN_W-1:0] ki;
		logic [GAIN_W-1:0] kd;
	} gains_t;

	typedef struct packed {
		logic valid;
		kind_t kind;
		logic done;
		logic turn;
	} ctl_t;

endpackage

// ----- src/pmc_if.sv -----
// Handshake channels for sample words and drive result words.
interface pmc_in_if #(parameter int POS_W = 24);
	logic valid;
	logic ready;
	logic mode;
	logic signed [POS_W-1:0] pos_a;
	logic signed [POS_W-1:0] pos_b;
	logic signed [POS_W-1:0] pos_c;
	logic signed [POS_W-1:0] pos_d;

	modport source(output valid, mode, pos_a, pos_b, pos_c, pos_d, input ready);
	modport sink(input valid, mode, pos_a, pos_b, pos_c, pos_d, output ready);
endinterface

interface pmc_out_if #(parameter int POS_W = 24, parameter int DRV_W = 15);
	logic valid;
	logic ready;
	logic signed [DRV_W-1:0] left_drive;
	logic signed [DRV_W-1:0] right_drive;
	logic move_done;
	logic signed [POS_W:0] error_out;

	modport source(output valid, left_drive, right_drive, move_done, error_out, input ready);
	modport sink(input valid, left_drive, right_drive, move_done, error_out, output ready);
endinterface

// ----- src/pmc_regs.sv -----
// APB register file holding the target, the mode select and both gain sets.
module pmc_regs #(
	parameter int POS_WIDTH = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [pmc_pkg::ADDR_W-1:0]     paddr,
	input  logic [pmc_pkg::DATA_W-1:0]     pwdata,
	output logic [pmc_pkg::DATA_W-1:0]     prdata,
	output logic                           pready,
	output logic signed [POS_WIDTH-1:0]    target,
	output logic                           turn,
	output pmc_pkg::gains_t                drive_gains,
	output pmc_pkg::gains_t                turn_gains
);
	import pmc_pkg::*;

	reg_idx_t idx;
	logic wr_en;
	logic signed [POS_WIDTH-1:0] target_q;
	logic turn_q;
	gains_t drive_q;
	gains_t turn_gains_q;

	assign idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			turn_q <= 1'b0;
			drive_q <= '0;
			turn_gains_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_TARGET: target_q <= pwdata[POS_WIDTH-1:0];
				REG_TURN:   turn_q <= pwdata[0];
				REG_DRV_P:  drive_q.kp <= pwdata[GAIN_W-1:0];
				REG_DRV_I:  drive_q.ki <= pwdata[GAIN_W-1:0];
				REG_DRV_D:  drive_q.kd <= pwdata[GAIN_W-1:0];
				REG_TRN_P:  turn_gains_q.kp <= pwdata[GAIN_W-1:0];
				REG_TRN_I:  turn_gains_q.ki <= pwdata[GAIN_W-1:0];
				REG_TRN_D:  turn_gains_q.kd <= pwdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Signed registers read back sign-extended to the bus width.
	always_comb begin
		case (idx)
			REG_TARGET: prdata = DATA_W'(target_q);
			REG_TURN:   prdata = {{(DATA_W-1){1'b0}}, turn_q};
			REG_DRV_P:  prdata = {{(DATA_W-GAIN_W){drive_q.kp[GAIN_W-1]}}, drive_q.kp};
			REG_DRV_I:  prdata = {{(DATA_W-GAIN_W){drive_q.ki[GAIN_W-1]}}, drive_q.ki};
			REG_DRV_D:  prdata = {{(DATA_W-GAIN_W){drive_q.kd[GAIN_W-1]}}, drive_q.kd};
			REG_TRN_P:  prdata = {{(DATA_W-GAIN_W){turn_gains_q.kp[GAIN_W-1]}},
				turn_gains_q.kp};
			REG_TRN_I:  prdata = {{(DATA_W-GAIN_W){turn_gains_q.ki[GAIN_W-1]}},
				turn_gains_q.ki};
			REG_TRN_D:  prdata = {{(DATA_W-GAIN_W){turn_gains_q.kd[GAIN_W-1]}},
				turn_gains_q.kd};
			default:    prdata = '0;
		endcase
	end

	assign target = target_q;
	assign turn = turn_q;
	assign drive_gains = drive_q;
	assign turn_gains = turn_gains_q;
endmodule

// ----- src/pmc_err.sv -----
// Error stage: measurement, error, integral, derivative and move state.
module pmc_err #(
	parameter int POS_WIDTH = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         valid_s0,
	input  logic                         mode_s0,
	input  logic signed [POS_WIDTH-1:0]  pos_a_s0,
	input  logic signed [POS_WIDTH-1:0]  pos_b_s0,
	input  logic signed [POS_WIDTH-1:0]  pos_c_s0,
	input  logic signed [POS_WIDTH-1:0]  pos_d_s0,
	input  logic signed [POS_WIDTH-1:0]  target,
	input  logic                         turn,
	input  pmc_pkg::gains_t              drive_gains,
	input  pmc_pkg::gains_t              turn_gains,
	output pmc_pkg::ctl_t                ctl_s1,
	output pmc_pkg::gains_t              gains_s1,
	output logic signed [POS_WIDTH:0]    err_s1,
	output logic signed [pmc_pkg::SUM_W-1:0] sum_s1,
	output logic signed [POS_WIDTH+1:0]  deriv_s1
);
	import pmc_pkg::*;

	localparam int WIDE_W = ((POS_WIDTH + 1 > SUM_W) ? POS_WIDTH + 1 : SUM_W) + 1;

	logic signed [SUM_W-1:0] error_sum_q;
	logic signed [POS_WIDTH:0] last_err_q;
	logic move_active_q;

	logic signed [POS_WIDTH+1:0] pos_sum;
	logic signed [POS_WIDTH-1:0] meas;
	logic signed [POS_WIDTH:0] err;
	logic signed [WIDE_W-1:0] sum_wide;
	logic signed [SUM_W-1:0] sum_sat;
	logic signed [SUM_W-1:0] sum_next;
	logic signed [POS_WIDTH+1:0] deriv;
	logic sum_fits;
	logic finish;
	kind_t kind;

	assign pos_sum = (POS_WIDTH+2)'(pos_a_s0) + (POS_WIDTH+2)'(pos_b_s0)
		+ (POS_WIDTH+2)'(pos_c_s0) + (POS_WIDTH+2)'(pos_d_s0);
	// Dropping the two low bits of the encoder sum is a floor average.
	assign meas = turn ? pos_a_s0 : pos_sum[POS_WIDTH+1:2];
	assign err = (POS_WIDTH+1)'(target) - (POS_WIDTH+1)'(meas);

	assign sum_wide = WIDE_W'(error_sum_q) + WIDE_W'(err);
	assign sum_fits = (&sum_wide[WIDE_W-1:SUM_W-1]) | ~(|sum_wide[WIDE_W-1:SUM_W-1]);
	assign sum_sat = sum_fits ? sum_wide[SUM_W-1:0]
		: (sum_wide[WIDE_W-1] ? SUM_MIN : SUM_MAX);

	assign deriv = (POS_WIDTH+2)'(err) - (POS_WIDTH+2)'(last_err_q);
	assign finish = err[POS_WIDTH] | ~(|err);
	assign sum_next = finish ? '0 : sum_sat;

	always_comb begin
		if (mode_s0 == MODE_START) begin
			kind = KIND_START;
		end else if (!move_active_q) begin
			kind = KIND_IDLE;
		end else begin
			kind = KIND_RUN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q <= '0;
			last_err_q <= '0;
			move_active_q <= 1'b0;
		end else if (en && valid_s0) begin
			case (kind)
				KIND_START: begin
					error_sum_q <= '0;
					last_err_q <= (POS_WIDTH+1)'(target);
					move_active_q <= 1'b1;
				end
				KIND_RUN: begin
					error_sum_q <= sum_next;
					last_err_q <= err;
					if (finish) begin
						move_active_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1.valid <= valid_s0;
			ctl_s1.kind <= kind;
			ctl_s1.done <= (kind == KIND_IDLE) | ((kind == KIND_RUN) & finish);
			ctl_s1.turn <= turn;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gains_s1 <= turn ? turn_gains : drive_gains;
			err_s1 <= err;
			sum_s1 <= sum_next;
			deriv_s1 <= deriv;
		end
	end

`ifndef SYNTHESIS
	a_arm_only_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(move_active_q) |-> $past(en && valid_s0 && mode_s0 == MODE_START))
		else $error("move armed without a start word");
`endif
endmodule

// ----- src/pmc_mac.sv -----
// Gain products, sum, scaling shift and drive saturation into the result register.
module pmc_mac #(
	parameter int POS_WIDTH = 24,
	parameter int GAIN_FRAC_BITS = 8,
	parameter int DRIVE_LIMIT = 12000,
	parameter int DRV_W = 15
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  pmc_pkg::ctl_t                    ctl_s1,
	input  pmc_pkg::gains_t                  gains_s1,
	input  logic signed [POS_WIDTH:0]        err_s1,
	input  logic signed [pmc_pkg::SUM_W-1:0] sum_s1,
	input  logic signed [POS_WIDTH+1:0]      deriv_s1,
	output logic                             valid_q,
	output logic signed [DRV_W-1:0]          left_q,
	output logic signed [DRV_W-1:0]          right_q,
	output logic                             done_q,
	output logic signed [POS_WIDTH:0]        err_q
);
	import pmc_pkg::*;

	localparam int PE_W = POS_WIDTH + 1 + GAIN_W;
	localparam int PI_W = SUM_W + GAIN_W;
	localparam int PD_W = POS_WIDTH + 2 + GAIN_W;
	localparam int ACC_W = ((PD_W > PI_W) ? PD_W : PI_W) + 2;

	ctl_t ctl_s2;
	logic signed [POS_WIDTH:0] err_s2;
	logic signed [PE_W-1:0] prod_e_s2;
	logic signed [PI_W-1:0] prod_i_s2;
	logic signed [PD_W-1:0] prod_d_s2;

	logic signed [ACC_W-1:0] acc;
	logic signed [ACC_W-1:0] scaled;
	logic signed [DRV_W-1:0] power;
	logic running;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			err_s2 <= err_s1;
			prod_e_s2 <= err_s1 * $signed(gains_s1.kp);
			prod_i_s2 <= sum_s1 * $signed(gains_s1.ki);
			prod_d_s2 <= deriv_s1 * $signed(gains_s1.kd);
		end
	end

	assign acc = ACC_W'(prod_e_s2) + ACC_W'(prod_i_s2) + ACC_W'(prod_d_s2);
	assign scaled = acc >>> GAIN_FRAC_BITS;
	assign running = (ctl_s2.kind == KIND_RUN);

	always_comb begin
		if (scaled > ACC_W'(DRIVE_LIMIT)) begin
			power = DRV_W'(DRIVE_LIMIT);
		end else if (scaled < -ACC_W'(DRIVE_LIMIT)) begin
			power = -DRV_W'(DRIVE_LIMIT);
		end else begin
			power = scaled[DRV_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= ctl_s2.valid;
		end
	end

	// Start and idle words report zero drive and zero error.
	always_ff @(posedge clk) begin
		if (en) begin
			left_q <= running ? power : '0;
			right_q <= running ? (ctl_s2.turn ? -power : power) : '0;
			done_q <= ctl_s2.done;
			err_q <= running ? err_s2 : '0;
		end
	end
endmodule

// ----- src/pid_move_controller_unit.sv -----
// Top level of the PID move controller: input register, error and gain stages.
//
// Configuration goes through the APB port; registers sit at byte address 4*i
// and the user must write them only while no word is in flight; the block does
// not enforce this. Each sample channel word is either a start word (mode 0),
// which arms a move and clears the integral, or a control sample (mode 1)
// carrying four encoder positions or, in turn mode, the rotation reading in
// pos_a. Every word yields exactly one result word on the result channel:
// left and right drive in millivolts, a done flag and the position error of
// that sample. The accepting edge loads the input register, and the word then
// passes through the error stage, the multiplier stage and the result
// register in that order. One word is accepted per cycle while the result
// channel takes words; the three gain products each have their own
// multiplier so none is shared.
// All stages advance together; when the receiver holds ready low with a result
// waiting, the whole pipeline and the sample channel stall and nothing is lost.
// Reset clears the registers, the integral, the previous error and the armed
// flag, and empties the pipeline.
module pid_move_controller_unit #(
	parameter int POS_WIDTH = 24,
	parameter int GAIN_FRAC_BITS = 8,
	parameter int DRIVE_LIMIT = 12000
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [pmc_pkg::ADDR_W-1:0]     paddr,
	input  logic [pmc_pkg::DATA_W-1:0]     pwdata,
	output logic [pmc_pkg::DATA_W-1:0]     prdata,
	output logic                           pready,
	pmc_in_if.sink                         sample_ch,
	pmc_out_if.source                      result_ch
);
	import pmc_pkg::*;

	localparam int DRV_W = $clog2(DRIVE_LIMIT + 1) + 1;

	logic en;
	logic valid_s0;
	logic mode_s0;
	logic signed [POS_WIDTH-1:0] pos_a_s0;
	logic signed [POS_WIDTH-1:0] pos_b_s0;
	logic signed [POS_WIDTH-1:0] pos_c_s0;
	logic signed [POS_WIDTH-1:0] pos_d_s0;

	logic signed [POS_WIDTH-1:0] target;
	logic turn;
	gains_t drive_gains;
	gains_t turn_gains;

	ctl_t ctl_s1;
	gains_t gains_s1;
	logic signed [POS_WIDTH:0] err_s1;
	logic signed [SUM_W-1:0] sum_s1;
	logic signed [POS_WIDTH+1:0] deriv_s1;

	logic valid_q;
	logic signed [DRV_W-1:0] left_q;
	logic signed [DRV_W-1:0] right_q;
	logic done_q;
	logic signed [POS_WIDTH:0] err_q;

	assign en = ~valid_q | result_ch.ready;
	assign sample_ch.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else if (en) begin
			valid_s0 <= sample_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && sample_ch.valid) begin
			mode_s0 <= sample_ch.mode;
			pos_a_s0 <= sample_ch.pos_a;
			pos_b_s0 <= sample_ch.pos_b;
			pos_c_s0 <= sample_ch.pos_c;
			pos_d_s0 <= sample_ch.pos_d;
		end
	end

	pmc_regs #(.POS_WIDTH(POS_WIDTH)) u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.target(target),
		.turn(turn),
		.drive_gains(drive_gains),
		.turn_gains(turn_gains)
	);

	pmc_err #(.POS_WIDTH(POS_WIDTH)) u_err (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.valid_s0(valid_s0),
		.mode_s0(mode_s0),
		.pos_a_s0(pos_a_s0),
		.pos_b_s0(pos_b_s0),
		.pos_c_s0(pos_c_s0),
		.pos_d_s0(pos_d_s0),
		.target(target),
		.turn(turn),
		.drive_gains(drive_gains),
		.turn_gains(turn_gains),
		.ctl_s1(ctl_s1),
		.gains_s1(gains_s1),
		.err_s1(err_s1),
		.sum_s1(sum_s1),
		.deriv_s1(deriv_s1)
	);

	pmc_mac #(
		.POS_WIDTH(POS_WIDTH),
		.GAIN_FRAC_BITS(GAIN_FRAC_BITS),
		.DRIVE_LIMIT(DRIVE_LIMIT),
		.DRV_W(DRV_W)
	) u_mac (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.ctl_s1(ctl_s1),
		.gains_s1(gains_s1),
		.err_s1(err_s1),
		.sum_s1(sum_s1),
		.deriv_s1(deriv_s1),
		.valid_q(valid_q),
		.left_q(left_q),
		.right_q(right_q),
		.done_q(done_q),
		.err_q(err_q)
	);

	assign result_ch.valid = valid_q;
	assign result_ch.left_drive = left_q;
	assign result_ch.right_drive = right_q;
	assign result_ch.move_done = done_q;
	assign result_ch.error_out = err_q;

`ifndef SYNTHESIS
	a_drive_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (left_q <= DRV_W'(DRIVE_LIMIT)) && (left_q >= -DRV_W'(DRIVE_LIMIT)))
		else $error("left drive beyond limit");
	a_sides_match: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (right_q == left_q) || (right_q == -left_q))
		else $error("right drive neither equal nor opposite to left");
	a_done_error: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && done_q) |-> (err_q <= 0))
		else $error("move reported done with positive error");
`endif
endmodule

// ----- verif/pid_move_controller_unit_tb.sv -----
// Self-checking testbench for the PID move controller: APB setup, sample words in, drive words out.
module pid_move_controller_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pmc_pkg::*;

	localparam int FRAC = 8;
	localparam longint LIMIT = 12000;
	localparam logic signed [23:0] POS_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] POS_MIN = 24'sh800000;

	typedef struct packed {
		logic signed [14:0] left;
		logic signed [14:0] right;
		logic done;
		logic signed [24:0] err;
	} drive_word_t;

	class pid_drive_predictor;
		logic signed [23:0] target;
		logic turn;
		gains_t drv_gains;
		gains_t trn_gains;
		logic signed [31:0] err_sum;
		logic signed [24:0] prev_err;
		logic armed;
		drive_word_t pending_drives[$];
		int mismatch_count;

		function new();
			target = '0;
			turn = 1'b0;
			drv_gains = '0;
			trn_gains = '0;
			err_sum = '0;
			prev_err = '0;
			armed = 1'b0;
			mismatch_count = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [31:0] value);
			case (idx)
				REG_TARGET: target = value[23:0];
				REG_TURN: turn = value[0];
				REG_DRV_P: drv_gains.kp = value[15:0];
				REG_DRV_I: drv_gains.ki = value[15:0];
				REG_DRV_D: drv_gains.kd = value[15:0];
				REG_TRN_P: trn_gains.kp = value[15:0];
				REG_TRN_I: trn_gains.ki = value[15:0];
				REG_TRN_D: trn_gains.kd = value[15:0];
				default: ;
			endcase
		endfunction

		// Works out the drive word that one accepted sample word must produce.
		function void note_word(logic mode, logic signed [23:0] a, logic signed [23:0] b,
				logic signed [23:0] c, logic signed [23:0] d);
			gains_t g;
			longint meas, err, sum, deriv, acc, power, rpow;
			drive_word_t want;
			want = '0;
			if (mode == MODE_START) begin
				err_sum = '0;
				prev_err = target;
				armed = 1'b1;
			end else if (!armed) begin
				want.done = 1'b1;
			end else begin
				if (turn) begin
					meas = a;
					g = trn_gains;
				end else begin
					meas = (longint'(a) + longint'(b) + longint'(c) + longint'(d)) >>> 2;
					g = drv_gains;
				end
				err = longint'(target) - meas;
				sum = longint'(err_sum) + err;
				if (sum > longint'($signed(SUM_MAX)))
					sum = longint'($signed(SUM_MAX));
				if (sum < longint'($signed(SUM_MIN)))
					sum = longint'($signed(SUM_MIN));
				deriv = err - longint'(prev_err);
				prev_err = err[24:0];
				// Reaching or passing the target ends the move and drops the integral.
				if (err <= 0) begin
					sum = 0;
					armed = 1'b0;
					want.done = 1'b1;
				end
				err_sum = sum[31:0];
				acc = err * longint'($signed(g.kp)) + sum * longint'($signed(g.ki))
					+ deriv * longint'($signed(g.kd));
				power = acc >>> FRAC;
				if (power > LIMIT)
					power = LIMIT;
				if (power < -LIMIT)
					power = -LIMIT;
				rpow = turn ? -power : power;
				want.left = power[14:0];
				want.right = rpow[14:0];
				want.err = err[24:0];
			end
			pending_drives.push_back(want);
		endfunction

		function void check_drive(drive_word_t got);
			drive_word_t want;
			if (pending_drives.size() == 0) begin
				mismatch_count++;
				$display("%t unexpected drive word: left %0d right %0d done %0d error %0d",
					$time, got.left, got.right, got.done, got.err);
			end else begin
				want = pending_drives.pop_front();
				if (got !== want) begin
					mismatch_count++;
					$display("%t drive mismatch: expected left %0d right %0d done %0d error %0d",
						$time, want.left, want.right, want.done, want.err);
					$display("%t                 actual   left %0d right %0d done %0d error %0d",
						$time, got.left, got.right, got.done, got.err);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	pmc_in_if #(.POS_W(24)) sample_ch();
	pmc_out_if #(.POS_W(24), .DRV_W(15)) result_ch();

	pid_drive_predictor drive_predictor = new();
	int tx_idle_pct;
	int rx_stall_pct;
	int sent_words;

	pid_move_controller_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.sample_ch(sample_ch),
		.result_ch(result_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#6_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// Result side: check every accepted drive word, then roll the stall for the next cycle.
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_ch.valid === 1'b1 && result_ch.ready)
				drive_predictor.check_drive({result_ch.left_drive, result_ch.right_drive,
					result_ch.move_done, result_ch.error_out});
			result_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	function automatic logic signed [23:0] rand24();
		return 24'($urandom());
	endfunction

	function automatic bit pos_ok(longint v);
		return v >= longint'(POS_MIN) && v <= longint'(POS_MAX);
	endfunction

	function automatic logic signed [15:0] pick_gain();
		int v;
		case ($urandom_range(5))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'($urandom());
			default: begin
				v = $urandom_range(1200);
				return 16'(v - 600);
			end
		endcase
	endfunction

	function automatic logic signed [23:0] pick_target();
		int v;
		case ($urandom_range(4))
			0: return POS_MAX;
			1: return POS_MIN;
			2: return '0;
			3: begin
				v = $urandom_range(10000);
				return 24'(v - 5000);
			end
			default: return rand24();
		endcase
	endfunction

	task automatic send_word(input logic mode, input logic signed [23:0] a,
			input logic signed [23:0] b, input logic signed [23:0] c,
			input logic signed [23:0] d);
		while ($urandom_range(99) < tx_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.mode <= mode;
		sample_ch.pos_a <= a;
		sample_ch.pos_b <= b;
		sample_ch.pos_c <= c;
		sample_ch.pos_d <= d;
		do
			@(posedge clk);
		while (!sample_ch.ready);
		drive_predictor.note_word(mode, a, b, c, d);
		sent_words++;
	endtask

	task automatic wait_drained();
		sample_ch.valid <= 1'b0;
		while (drive_predictor.pending_drives.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		drive_predictor.set_reg(idx, value);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input logic signed [23:0] tgt, input logic trn,
			input logic signed [15:0] dp, input logic signed [15:0] di,
			input logic signed [15:0] dd, input logic signed [15:0] tp,
			input logic signed [15:0] ti, input logic signed [15:0] td);
		wait_drained();
		write_reg(REG_TARGET, 32'(tgt));
		write_reg(REG_TURN, {31'd0, trn});
		write_reg(REG_DRV_P, 32'(dp));
		write_reg(REG_DRV_I, 32'(di));
		write_reg(REG_DRV_D, 32'(dd));
		write_reg(REG_TRN_P, 32'(tp));
		write_reg(REG_TRN_I, 32'(ti));
		write_reg(REG_TRN_D, 32'(td));
	endtask

	// Sends a sample whose measured position is m: the rotation reading in turn mode,
	// otherwise four encoders spread around m whose floor average is m.
	task automatic send_at(input longint m);
		longint o1, o2, o3, r, va, vb, vc, vd;
		if (drive_predictor.turn) begin
			send_word(MODE_SAMPLE, 24'(m), rand24(), rand24(), rand24());
		end else begin
			o1 = longint'($urandom_range(4000)) - 2000;
			o2 = longint'($urandom_range(4000)) - 2000;
			o3 = longint'($urandom_range(4000)) - 2000;
			r = $urandom_range(3);
			va = m + o1;
			vb = m + o2;
			vc = m + o3;
			vd = m + r - o1 - o2 - o3;
			if (!(pos_ok(va) && pos_ok(vb) && pos_ok(vc) && pos_ok(vd))) begin
				va = m;
				vb = m;
				vc = m;
				vd = m;
			end
			send_word(MODE_SAMPLE, 24'(va), 24'(vb), 24'(vc), 24'(vd));
		end
	endtask

	// One move: a start word, then samples closing in on the target, ending on or past it
	// unless the segment runs out of room first.
	task automatic run_move(input int room);
		int len;
		int scale;
		longint e, m;
		len = ($urandom_range(7) == 0) ? $urandom_range(300, 40) : $urandom_range(20, 1);
		if (len > room - 1)
			len = room - 1;
		scale = $urandom_range(2);
		send_word(MODE_START, rand24(), rand24(), rand24(), rand24());
		for (int k = 0; k < len; k++) begin
			if (k == len - 1 || $urandom_range(19) == 0)
				e = -longint'($urandom_range(scale == 0 ? 4 : 100000));
			else
				case (scale)
					0: e = $urandom_range(100, 1);
					1: e = $urandom_range(100000, 1);
					default: e = $urandom_range(16777215, 4000000);
				endcase
			m = longint'(drive_predictor.target) - e;
			if (m > longint'(POS_MAX))
				m = POS_MAX;
			if (m < longint'(POS_MIN))
				m = POS_MIN;
			send_at(m);
		end
	endtask

	task automatic run_segment(input logic trn);
		int quota;
		set_config(pick_target(), trn, pick_gain(), pick_gain(), pick_gain(),
			pick_gain(), pick_gain(), pick_gain());
		quota = sent_words + 237;
		while (sent_words < quota) begin
			if ($urandom_range(9) == 0)
				send_word(1'($urandom_range(1)), rand24(), rand24(), rand24(), rand24());
			else
				run_move(quota - sent_words);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sample_ch.valid = 1'b0;
		sample_ch.mode = MODE_START;
		sample_ch.pos_a = '0;
		sample_ch.pos_b = '0;
		sample_ch.pos_c = '0;
		sample_ch.pos_d = '0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		sent_words = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A sample with no move armed reports done.
		send_word(MODE_SAMPLE, rand24(), rand24(), rand24(), rand24());

		// Widest error and extreme gains in straight mode, then restart of a live move.
		set_config(POS_MAX, 1'b0, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
			16'sh8000, 16'sh7FFF, 16'sh8000);
		send_word(MODE_START, '0, '0, '0, '0);
		send_word(MODE_SAMPLE, POS_MIN, POS_MIN, POS_MIN, POS_MIN);
		send_word(MODE_SAMPLE, -24'sd1, '0, '0, '0);
		send_word(MODE_SAMPLE, POS_MAX, POS_MAX, POS_MAX, POS_MAX);
		send_word(MODE_SAMPLE, '0, '0, '0, '0);
		send_word(MODE_START, rand24(), rand24(), rand24(), rand24());
		send_word(MODE_START, rand24(), rand24(), rand24(), rand24());
		send_word(MODE_SAMPLE, POS_MAX, POS_MAX, POS_MAX, POS_MAX - 24'sd1);
		send_word(MODE_SAMPLE, POS_MAX, POS_MAX, POS_MAX, POS_MAX);

		// Turn mode at the lowest target: overshoot and exact arrival.
		set_config(POS_MIN, 1'b1, '0, '0, '0, 16'sh8000, 16'sh8000, 16'sh8000);
		send_word(MODE_START, rand24(), rand24(), rand24(), rand24());
		send_word(MODE_SAMPLE, POS_MAX, rand24(), rand24(), rand24());
		send_word(MODE_START, rand24(), rand24(), rand24(), rand24());
		send_word(MODE_SAMPLE, POS_MIN, rand24(), rand24(), rand24());

		// A modest turn that converges and then overshoots by one.
		set_config(24'sd1000, 1'b1, 16'sd256, '0, '0, 16'sd256, 16'sd16, 16'sd64);
		send_word(MODE_START, rand24(), rand24(), rand24(), rand24());
		send_word(MODE_SAMPLE, '0, rand24(), rand24(), rand24());
		send_word(MODE_SAMPLE, 24'sd500, rand24(), rand24(), rand24());
		send_word(MODE_SAMPLE, 24'sd900, rand24(), rand24(), rand24());
		send_word(MODE_SAMPLE, 24'sd999, rand24(), rand24(), rand24());
		send_word(MODE_SAMPLE, 24'sd1001, rand24(), rand24(), rand24());

		// Negative encoder sum exercises the floor in the average.
		set_config('0, 1'b0, 16'sd300, 16'sd20, -16'sd40, '0, '0, '0);
		send_word(MODE_START, rand24(), rand24(), rand24(), rand24());
		send_word(MODE_SAMPLE, -24'sd5, -24'sd6, -24'sd7, -24'sd8);
		send_word(MODE_SAMPLE, '0, '0, '0, '0);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					tx_idle_pct = 0;
					rx_stall_pct = 0;
				end
				1: begin
					tx_idle_pct = 72;
					rx_stall_pct = 0;
				end
				2: begin
					tx_idle_pct = 0;
					rx_stall_pct = 72;
				end
				default: begin
					tx_idle_pct = 19;
					rx_stall_pct = 19;
				end
			endcase
			run_segment(1'b0);
			run_segment(1'b1);
		end

		wait_drained();
		if (drive_predictor.mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
